[rtl/core/hsvbct_pkg.sv]
// Shared types, constants and helpers for the HSV blob centroid tracker.
package hsvbct_pkg;

	localparam int unsigned SUM_W    = 25;
	localparam int unsigned CNT_W    = 17;
	localparam int unsigned COORD_W  = 10;
	localparam int unsigned CHAN_W   = 8;
	localparam int unsigned SQ_W     = 22;
	localparam int unsigned ERR_W    = 12;
	localparam int unsigned TOTAL_W  = 21;
	localparam int unsigned STEER_W  = 3;
	localparam int unsigned STEP_W   = 5;

	localparam logic [STEP_W-1:0] DIV_STEPS  = 5'd25;
	localparam logic [STEP_W-1:0] ROOT_STEPS = 5'd11;

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_INIT = 17'd1;
	localparam logic [SQ_W-1:0]  ROOT_BIT0 = 22'h100000;

	localparam logic [STEER_W-1:0] STEER_NONE       = 3'd0;
	localparam logic [STEER_W-1:0] STEER_DOWN_RIGHT = 3'd1;
	localparam logic [STEER_W-1:0] STEER_UP_RIGHT   = 3'd2;
	localparam logic [STEER_W-1:0] STEER_DOWN_LEFT  = 3'd3;
	localparam logic [STEER_W-1:0] STEER_UP_LEFT    = 3'd4;

	typedef enum logic [2:0] {
		REG_REF_HUE  = 3'd0,
		REG_REF_SAT  = 3'd1,
		REG_REF_VAL  = 3'd2,
		REG_TOL_HUE  = 3'd3,
		REG_TOL_SAT  = 3'd4,
		REG_TOL_VAL  = 3'd5,
		REG_CENTER_X = 3'd6,
		REG_CENTER_Y = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SQUARE,
		ST_RINIT,
		ST_ROOT,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic [CHAN_W-1:0]  ref_hue;
		logic [CHAN_W-1:0]  ref_sat;
		logic [CHAN_W-1:0]  ref_val;
		logic [CHAN_W-1:0]  tol_hue;
		logic [CHAN_W-1:0]  tol_sat;
		logic [CHAN_W-1:0]  tol_val;
		logic [COORD_W-1:0] center_x;
		logic [COORD_W-1:0] center_y;
	} cfg_t;

	typedef struct packed {
		logic accum;
		logic frame_end;
		logic div_step;
		logic square;
		logic root_init;
		logic root_step;
		logic out_load;
	} cmd_t;

	function automatic logic in_window(input logic [CHAN_W-1:0] p, input logic [CHAN_W-1:0] r,
		input logic [CHAN_W-1:0] t);
		logic signed [CHAN_W+1:0] lo;
		logic [CHAN_W:0] hi;
		lo = $signed({2'b00, r}) - $signed({2'b00, t});
		hi = {1'b0, r} + {1'b0, t};
		return ($signed({2'b00, p}) >= lo) && ({1'b0, p} <= hi);
	endfunction

endpackage

[rtl/core/hsvbct_regs.sv]
// Configuration register file behind the APB-style port.
module hsvbct_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output hsvbct_pkg::cfg_t    cfg
);

	hsvbct_pkg::cfg_t    cfg_q;
	hsvbct_pkg::reg_idx_t idx;
	logic                wr_en;

	assign idx    = hsvbct_pkg::reg_idx_t'(paddr[4:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ref_hue  <= 8'd0;
			cfg_q.ref_sat  <= 8'd0;
			cfg_q.ref_val  <= 8'd0;
			cfg_q.tol_hue  <= 8'd20;
			cfg_q.tol_sat  <= 8'd50;
			cfg_q.tol_val  <= 8'd80;
			cfg_q.center_x <= 10'd160;
			cfg_q.center_y <= 10'd120;
		end else if (wr_en) begin
			unique case (idx)
				hsvbct_pkg::REG_REF_HUE:  cfg_q.ref_hue  <= pwdata[7:0];
				hsvbct_pkg::REG_REF_SAT:  cfg_q.ref_sat  <= pwdata[7:0];
				hsvbct_pkg::REG_REF_VAL:  cfg_q.ref_val  <= pwdata[7:0];
				hsvbct_pkg::REG_TOL_HUE:  cfg_q.tol_hue  <= pwdata[7:0];
				hsvbct_pkg::REG_TOL_SAT:  cfg_q.tol_sat  <= pwdata[7:0];
				hsvbct_pkg::REG_TOL_VAL:  cfg_q.tol_val  <= pwdata[7:0];
				hsvbct_pkg::REG_CENTER_X: cfg_q.center_x <= pwdata[9:0];
				hsvbct_pkg::REG_CENTER_Y: cfg_q.center_y <= pwdata[9:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			hsvbct_pkg::REG_REF_HUE:  prdata = {24'd0, cfg_q.ref_hue};
			hsvbct_pkg::REG_REF_SAT:  prdata = {24'd0, cfg_q.ref_sat};
			hsvbct_pkg::REG_REF_VAL:  prdata = {24'd0, cfg_q.ref_val};
			hsvbct_pkg::REG_TOL_HUE:  prdata = {24'd0, cfg_q.tol_hue};
			hsvbct_pkg::REG_TOL_SAT:  prdata = {24'd0, cfg_q.tol_sat};
			hsvbct_pkg::REG_TOL_VAL:  prdata = {24'd0, cfg_q.tol_val};
			hsvbct_pkg::REG_CENTER_X: prdata = {22'd0, cfg_q.center_x};
			hsvbct_pkg::REG_CENTER_Y: prdata = {22'd0, cfg_q.center_y};
		endcase
	end

endmodule

[rtl/core/hsvbct_ctrl.sv]
// Sequencer for accumulation, division, squaring, square root and result hand-off.
module hsvbct_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pix_valid,
	input  logic               end_of_frame,
	output logic               pix_stall,
	output logic               res_valid,
	input  logic               res_stall,
	output hsvbct_pkg::cmd_t   cmd
);

	hsvbct_pkg::state_t state_q, state_nx;
	logic [hsvbct_pkg::STEP_W-1:0] step_q;
	logic res_valid_q;
	logic out_free;
	logic step_last;

	assign out_free  = !res_valid_q || !res_stall;
	assign step_last = (step_q == '0);
	assign res_valid = res_valid_q;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			hsvbct_pkg::ST_IDLE:   if (pix_valid && end_of_frame) state_nx = hsvbct_pkg::ST_DIV;
			hsvbct_pkg::ST_DIV:    if (step_last) state_nx = hsvbct_pkg::ST_SQUARE;
			hsvbct_pkg::ST_SQUARE: state_nx = hsvbct_pkg::ST_RINIT;
			hsvbct_pkg::ST_RINIT:  state_nx = hsvbct_pkg::ST_ROOT;
			hsvbct_pkg::ST_ROOT:   if (step_last) state_nx = hsvbct_pkg::ST_HOLD;
			hsvbct_pkg::ST_HOLD:   if (out_free) state_nx = hsvbct_pkg::ST_IDLE;
			default:               state_nx = hsvbct_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		pix_stall = 1'b1;
		unique case (state_q)
			hsvbct_pkg::ST_IDLE: begin
				pix_stall     = 1'b0;
				cmd.accum     = pix_valid;
				cmd.frame_end = pix_valid && end_of_frame;
			end
			hsvbct_pkg::ST_DIV:    cmd.div_step  = 1'b1;
			hsvbct_pkg::ST_SQUARE: cmd.square    = 1'b1;
			hsvbct_pkg::ST_RINIT:  cmd.root_init = 1'b1;
			hsvbct_pkg::ST_ROOT:   cmd.root_step = 1'b1;
			hsvbct_pkg::ST_HOLD:   cmd.out_load  = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hsvbct_pkg::ST_IDLE;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.frame_end) begin
				step_q <= hsvbct_pkg::DIV_STEPS - 5'd1;
			end else if (cmd.root_init) begin
				step_q <= hsvbct_pkg::ROOT_STEPS - 5'd1;
			end else if ((cmd.div_step || cmd.root_step) && !step_last) begin
				step_q <= step_q - 5'd1;
			end
			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/core/hsvbct_dp.sv]
// Datapath: match test, accumulators, dividers, squares, square root and result registers.
module hsvbct_dp #(
	parameter int unsigned FRAME_WIDTH  = 320,
	parameter int unsigned FRAME_HEIGHT = 240
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  hsvbct_pkg::cfg_t       cfg,
	input  hsvbct_pkg::cmd_t       cmd,
	input  logic [9:0]             pixel_row,
	input  logic [9:0]             pixel_col,
	input  logic [7:0]             pixel_hue,
	input  logic [7:0]             pixel_sat,
	input  logic [7:0]             pixel_val,
	output logic [9:0]             centroid_row,
	output logic [9:0]             centroid_col,
	output logic [2:0]             steer_code,
	output logic signed [11:0]     signed_error,
	output logic [20:0]            match_total
);

	localparam int unsigned SW = hsvbct_pkg::SUM_W;
	localparam int unsigned CW = hsvbct_pkg::CNT_W;
	localparam int unsigned QW = hsvbct_pkg::SQ_W;

	logic [SW-1:0] row_sum_q, col_sum_q, row_sum_nx, col_sum_nx;
	logic [CW-1:0] cnt_q, cnt_nx;
	logic [SW:0]   row_add, col_add;
	logic [CW:0]   cnt_add;
	logic          in_frame, match;

	logic [SW-1:0] quo_row_q, quo_col_q;
	logic [CW-1:0] rem_row_q, rem_col_q, total_q;
	logic [CW:0]   sh_row, sh_col;
	logic [CW+1:0] df_row, df_col;
	logic          ge_row, ge_col;

	logic [9:0]         cc, cr;
	logic signed [10:0] dx, dy;
	logic signed [QW-1:0] dx_w, dy_w;
	logic [QW-1:0]      sqx, sqy, sqx_q, sqy_q;
	logic [2:0]         steer_q, steer_nx;
	logic               right_q;

	logic [QW-1:0] rx_q, res_q, bit_q, trial;
	logic [11:0]   root12;

	assign in_frame = ({1'b0, pixel_row} < 11'(FRAME_HEIGHT))
		&& ({1'b0, pixel_col} < 11'(FRAME_WIDTH));
	assign match = in_frame
		&& hsvbct_pkg::in_window(pixel_hue, cfg.ref_hue, cfg.tol_hue)
		&& hsvbct_pkg::in_window(pixel_sat, cfg.ref_sat, cfg.tol_sat)
		&& hsvbct_pkg::in_window(pixel_val, cfg.ref_val, cfg.tol_val);

	assign row_add = {1'b0, row_sum_q} + {16'd0, pixel_row};
	assign col_add = {1'b0, col_sum_q} + {16'd0, pixel_col};
	assign cnt_add = {1'b0, cnt_q} + 18'd1;

	always_comb begin
		row_sum_nx = row_sum_q;
		col_sum_nx = col_sum_q;
		cnt_nx     = cnt_q;
		if (match) begin
			row_sum_nx = row_add[SW] ? hsvbct_pkg::SUM_MAX : row_add[SW-1:0];
			col_sum_nx = col_add[SW] ? hsvbct_pkg::SUM_MAX : col_add[SW-1:0];
			cnt_nx     = cnt_add[CW] ? hsvbct_pkg::CNT_MAX : cnt_add[CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_sum_q <= '0;
			col_sum_q <= '0;
			cnt_q     <= hsvbct_pkg::CNT_INIT;
		end else if (cmd.frame_end) begin
			row_sum_q <= '0;
			col_sum_q <= '0;
			cnt_q     <= hsvbct_pkg::CNT_INIT;
		end else if (cmd.accum) begin
			row_sum_q <= row_sum_nx;
			col_sum_q <= col_sum_nx;
			cnt_q     <= cnt_nx;
		end
	end

	assign sh_row = {rem_row_q, quo_row_q[SW-1]};
	assign sh_col = {rem_col_q, quo_col_q[SW-1]};
	assign df_row = {1'b0, sh_row} - {2'b00, total_q};
	assign df_col = {1'b0, sh_col} - {2'b00, total_q};
	assign ge_row = !df_row[CW+1];
	assign ge_col = !df_col[CW+1];

	always_ff @(posedge clk) begin
		if (cmd.frame_end) begin
			quo_row_q <= row_sum_nx;
			quo_col_q <= col_sum_nx;
			rem_row_q <= '0;
			rem_col_q <= '0;
			total_q   <= cnt_nx;
		end else if (cmd.div_step) begin
			quo_row_q <= {quo_row_q[SW-2:0], ge_row};
			quo_col_q <= {quo_col_q[SW-2:0], ge_col};
			rem_row_q <= ge_row ? df_row[CW-1:0] : sh_row[CW-1:0];
			rem_col_q <= ge_col ? df_col[CW-1:0] : sh_col[CW-1:0];
		end
	end

	assign cr   = quo_row_q[9:0];
	assign cc   = quo_col_q[9:0];
	assign dx   = $signed({1'b0, cfg.center_x}) - $signed({1'b0, cc});
	assign dy   = $signed({1'b0, cfg.center_y}) - $signed({1'b0, cr});
	assign dx_w = QW'(dx);
	assign dy_w = QW'(dy);
	assign sqx  = dx_w * dx_w;
	assign sqy  = dy_w * dy_w;

	always_comb begin
		priority if (cc > cfg.center_x && cr > cfg.center_y) begin
			steer_nx = hsvbct_pkg::STEER_DOWN_RIGHT;
		end else if (cc > cfg.center_x && cr < cfg.center_y) begin
			steer_nx = hsvbct_pkg::STEER_UP_RIGHT;
		end else if (cc < cfg.center_x && cr > cfg.center_y) begin
			steer_nx = hsvbct_pkg::STEER_DOWN_LEFT;
		end else if (cc < cfg.center_x && cr < cfg.center_y) begin
			steer_nx = hsvbct_pkg::STEER_UP_LEFT;
		end else begin
			steer_nx = hsvbct_pkg::STEER_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.square) begin
			sqx_q   <= sqx;
			sqy_q   <= sqy;
			steer_q <= steer_nx;
			right_q <= cc > cfg.center_x;
		end
	end

	assign trial = res_q + bit_q;

	always_ff @(posedge clk) begin
		if (cmd.root_init) begin
			rx_q  <= sqx_q + sqy_q;
			res_q <= '0;
			bit_q <= hsvbct_pkg::ROOT_BIT0;
		end else if (cmd.root_step) begin
			if (rx_q >= trial) begin
				rx_q  <= rx_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root12 = res_q[11:0];

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			centroid_row <= cr;
			centroid_col <= cc;
			steer_code   <= steer_q;
			signed_error <= right_q ? -$signed(root12) : $signed(root12);
			match_total  <= {4'd0, total_q};
		end
	end

endmodule

[rtl/core/hsv_blob_centroid_tracker.sv]
// Top level of the HSV blob centroid tracker.
// Pixel beats: one per cycle while no frame result is being computed or waiting for the output.
// A beat with end_of_frame starts a pass (radix-2 divide, square, root init, square root) during which
// pixel beats stall; the result then waits in the hold state until the output register is free.
// Reset clears control, accumulators (count to one) and loads configuration defaults.
module hsv_blob_centroid_tracker #(
	parameter int unsigned FRAME_WIDTH  = 320,
	parameter int unsigned FRAME_HEIGHT = 240
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               pix_valid,
	output logic               pix_stall,
	input  logic [9:0]         pixel_row,
	input  logic [9:0]         pixel_col,
	input  logic [7:0]         pixel_hue,
	input  logic [7:0]         pixel_sat,
	input  logic [7:0]         pixel_val,
	input  logic               end_of_frame,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [9:0]         centroid_row,
	output logic [9:0]         centroid_col,
	output logic [2:0]         steer_code,
	output logic signed [11:0] signed_error,
	output logic [20:0]        match_total
);

	hsvbct_pkg::cfg_t cfg;
	hsvbct_pkg::cmd_t cmd;

	hsvbct_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	hsvbct_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.pix_valid    (pix_valid),
		.end_of_frame (end_of_frame),
		.pix_stall    (pix_stall),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.cmd          (cmd)
	);

	hsvbct_dp #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.pixel_row    (pixel_row),
		.pixel_col    (pixel_col),
		.pixel_hue    (pixel_hue),
		.pixel_sat    (pixel_sat),
		.pixel_val    (pixel_val),
		.centroid_row (centroid_row),
		.centroid_col (centroid_col),
		.steer_code   (steer_code),
		.signed_error (signed_error),
		.match_total  (match_total)
	);

	a_eof_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && !pix_stall && end_of_frame) |=> pix_stall)
		else $error("pixel beat taken right after end of frame");

	a_total_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (match_total != 21'd0))
		else $error("result beat with zero match total");

	a_tie_no_steer: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (centroid_col == cfg.center_x || centroid_row == cfg.center_y))
		|-> (steer_code == hsvbct_pkg::STEER_NONE))
		else $error("steer command on a tie");

	a_neg_right: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && signed_error[11]) |-> (centroid_col > cfg.center_x))
		else $error("negative error with centroid not right of center");

endmodule
